// File: rtl/dpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_pkg
// Item types and fixed constants of the depth pixel deprojection unit.
// ----------------------------------------------------------------------------
package dpd_pkg;

  // coordinate and scale widths
  localparam int COORD_W = 40;
  localparam int Z_W     = 23;
  localparam int PP_W    = 20;
  localparam int INV_W   = 32;
  localparam int PIX_W   = 12;
  localparam int DEPTH_W = 16;

  // depth to z: z = floor((depth*8192 + 62) / 125), done as multiply by
  // ceil(2^37 / 125) and a right shift by 37
  localparam logic [30:0] Z_RECIP = 31'd1099511628;
  localparam int          Z_SHIFT = 37;
  localparam logic [12:0] Z_BIAS  = 13'd62;

  // total register stages from accept to result strobe
  localparam int LATENCY = 5;

  // saturation bounds
  localparam logic signed [COORD_W-1:0] COORD_MAX = 40'sh7f_ffff_ffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 40'sh80_0000_0000;

  // configuration register indexes
  localparam logic [7:0] REG_PRINCIPAL_X = 8'd0;
  localparam logic [7:0] REG_PRINCIPAL_Y = 8'd1;
  localparam logic [7:0] REG_INV_FOCAL_X = 8'd2;
  localparam logic [7:0] REG_INV_FOCAL_Y = 8'd3;

  // configuration reset values
  localparam logic [PP_W-1:0]  PRINCIPAL_X_RST = 20'd81920;
  localparam logic [PP_W-1:0]  PRINCIPAL_Y_RST = 20'd61440;
  localparam logic [INV_W-1:0] INV_FOCAL_X_RST = 32'd7158278;
  localparam logic [INV_W-1:0] INV_FOCAL_Y_RST = 32'd7158278;

  typedef struct packed {
    logic [PIX_W-1:0]   column;
    logic [PIX_W-1:0]   row;
    logic [DEPTH_W-1:0] depth_mm;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [31:0]               point_z;
    logic [23:0]               packed_rgb;
    logic                      point_valid;
    logic                      frame_last;
  } point_t;

  // item sideband that travels next to the axis pipelines
  typedef struct packed {
    logic             vld;
    logic             pv;
    logic [23:0]      rgb;
    logic             last;
    logic [Z_W-1:0]   z;
  } side_t;

endpackage

// File: rtl/depth_pixel_deprojection_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_deprojection_unit
// Pinhole deprojection of depth pixels into fixed point 3-D points.
// ----------------------------------------------------------------------------
// A pixel item is taken at every clock edge with start high and busy low;
// busy is high only during reset. Each item yields one point item at the
// end of the axis pipelines and sideband delay line, shown on point for
// one cycle with point_strobe high. The receiver cannot hold results off,
// and none is needed: outside reset the pipeline takes one pixel per clock
// and its depth is set by the 43 by 32 bit focal multiply, split into a 32
// by 32 and an 11 by 32 bit partial product over two stages. Zero depth or
// a column or row at or above IMAGE_DIM_MAX gives point_valid low with all
// other fields zero except frame_last. Configuration writes are always
// ready and take effect at once; change them only with no items in flight.
// ----------------------------------------------------------------------------
module depth_pixel_deprojection_unit
  import dpd_pkg::*;
#(
  parameter int IMAGE_DIM_MAX = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pixel_t      pixel,
  output logic        point_strobe,
  output point_t      point,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [PP_W-1:0]  principal_x;
  logic [PP_W-1:0]  principal_y;
  logic [INV_W-1:0] inv_focal_x;
  logic [INV_W-1:0] inv_focal_y;

  logic accept;
  logic in_frame;
  logic pv_c;
  logic [Z_W-1:0] z_c;
  side_t side [1:LATENCY];
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      principal_x <= PRINCIPAL_X_RST;
      principal_y <= PRINCIPAL_Y_RST;
      inv_focal_x <= INV_FOCAL_X_RST;
      inv_focal_y <= INV_FOCAL_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PRINCIPAL_X: principal_x <= cfg_data[PP_W-1:0];
        REG_PRINCIPAL_Y: principal_y <= cfg_data[PP_W-1:0];
        REG_INV_FOCAL_X: inv_focal_x <= cfg_data;
        REG_INV_FOCAL_Y: inv_focal_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // point valid check: measured depth and pixel within the frame bound
  assign in_frame = (32'(pixel.column) < 32'(IMAGE_DIM_MAX)) &&
                    (32'(pixel.row) < 32'(IMAGE_DIM_MAX));
  assign pv_c     = (pixel.depth_mm != '0) && in_frame;

  dpd_zscale u_zscale (
    .en       (pv_c),
    .depth_mm (pixel.depth_mm),
    .z        (z_c)
  );

  dpd_axis u_axis_x (
    .clk   (clk),
    .en    (pv_c),
    .pix   (pixel.column),
    .pp    (principal_x),
    .inv   (inv_focal_x),
    .z     (side[1].z),
    .coord (coord_x)
  );

  dpd_axis u_axis_y (
    .clk   (clk),
    .en    (pv_c),
    .pix   (pixel.row),
    .pp    (principal_y),
    .inv   (inv_focal_y),
    .z     (side[1].z),
    .coord (coord_y)
  );

  // stage 1 capture of sideband
  always_ff @(posedge clk) begin
    if (rst) begin
      side[1].vld <= 1'b0;
    end else begin
      side[1].vld <= accept;
    end
    side[1].pv   <= pv_c;
    side[1].rgb  <= pv_c ? {pixel.red, pixel.green, pixel.blue} : 24'd0;
    side[1].last <= pixel.frame_end;
    side[1].z    <= z_c;
  end

  // sideband delay line matching the axis pipelines
  for (genvar s = 2; s <= LATENCY; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[s].vld <= 1'b0;
      end else begin
        side[s].vld <= side[s-1].vld;
      end
      side[s].pv   <= side[s-1].pv;
      side[s].rgb  <= side[s-1].rgb;
      side[s].last <= side[s-1].last;
      side[s].z    <= side[s-1].z;
    end
  end

  // result item
  assign point_strobe      = side[LATENCY].vld;
  assign point.point_x     = coord_x;
  assign point.point_y     = coord_y;
  assign point.point_z     = 32'(side[LATENCY].z);
  assign point.packed_rgb  = side[LATENCY].rgb;
  assign point.point_valid = side[LATENCY].pv;
  assign point.frame_last  = side[LATENCY].last;

endmodule

// File: rtl/dpd_zscale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_zscale
// Millimetre depth to metres with 16 fractional bits, rounded half up,
// by a constant reciprocal multiply. Combinational; the caller registers z
// together with the rest of the stage one sideband.
// ----------------------------------------------------------------------------
module dpd_zscale
  import dpd_pkg::*;
(
  input  logic               en,
  input  logic [DEPTH_W-1:0] depth_mm,
  output logic [Z_W-1:0]     z
);

  logic [28:0] num;
  logic [59:0] prod;

  // (depth*65536 + 500) / 1000 reduces to (depth*8192 + 62) / 125
  assign num  = {depth_mm, Z_BIAS};
  assign prod = 60'(num) * 60'(Z_RECIP);

  // zero for points that are not valid
  assign z = en ? prod[Z_SHIFT+Z_W-1:Z_SHIFT] : '0;

endmodule

// File: rtl/dpd_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpd_axis
// One coordinate axis: ((pix*256 - pp) * z * inv) >> 40 with floor and
// 40-bit saturation, as a five stage pipeline. z enters one stage after pix.
// ----------------------------------------------------------------------------
module dpd_axis
  import dpd_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic [PIX_W-1:0]          pix,
  input  logic [PP_W-1:0]           pp,
  input  logic [INV_W-1:0]          inv,
  input  logic [Z_W-1:0]            z,
  output logic signed [COORD_W-1:0] coord
);

  logic [PP_W-1:0]  pos;
  logic             neg_c;
  logic             neg1, neg2, neg3, neg4;
  logic [PP_W-1:0]  mag1;
  logic [42:0]      a2;
  logic [63:0]      p0;
  logic [42:0]      p1;
  logic [74:0]      full;
  logic [34:0]      q4;
  logic             rem4;
  logic [40:0]      qn;
  logic signed [COORD_W-1:0] coord_next;

  // stage 1: offset from principal point as sign and magnitude
  assign pos   = {pix, 8'd0};
  assign neg_c = en && (pp > pos);

  always_ff @(posedge clk) begin
    neg1 <= neg_c;
    if (!en) begin
      mag1 <= '0;
    end else if (neg_c) begin
      mag1 <= pp - pos;
    end else begin
      mag1 <= pos - pp;
    end
  end

  // stage 2: magnitude times depth
  always_ff @(posedge clk) begin
    neg2 <= neg1;
    a2   <= 43'(mag1) * 43'(z);
  end

  // stage 3: partial products with the reciprocal focal length
  always_ff @(posedge clk) begin
    neg3 <= neg2;
    p0   <= 64'(a2[31:0]) * 64'(inv);
    p1   <= 43'(a2[42:32]) * 43'(inv);
  end

  // stage 4: combine partials, keep quotient and sticky remainder
  assign full = {p1, 32'd0} + 75'(p0);

  always_ff @(posedge clk) begin
    neg4 <= neg3;
    q4   <= full[74:40];
    rem4 <= |full[39:0];
  end

  // stage 5: apply sign with floor rounding and saturate
  assign qn = 41'(q4) + 41'(rem4);

  always_comb begin
    if (neg4) begin
      if (qn > 41'h100_0000_0000 >> 1) begin
        coord_next = COORD_MIN;
      end else begin
        coord_next = -$signed(qn[39:0]);
      end
    end else begin
      if (41'(q4) > 41'(COORD_MAX)) begin
        coord_next = COORD_MAX;
      end else begin
        coord_next = $signed(40'(q4));
      end
    end
  end

  always_ff @(posedge clk) begin
    coord <= coord_next;
  end

endmodule
